/* design/chf_pkg.sv */
// Shared types and constants for the cholesky upper factor core.
// Holds the arithmetic unit operation codes and request struct; no dependencies.
package chf_pkg;

	// default largest matrix order
	localparam int MAX_ORDER_DEF = 8;

	// configuration register width and reset value
	localparam int ORD_W = 4;
	localparam logic [ORD_W-1:0] ORDER_RESET = 4'd8;

	// data widths
	localparam int DATA_W = 32;
	localparam int ROOT_W = 24;
	localparam int PROD_W = 64;

	// arithmetic unit operation codes
	localparam logic [1:0] OP_SQRT = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_MUL  = 2'd2;

	// request from sequencer to arithmetic unit
	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} chf_req_t;

endpackage

/* design/chf_alu.sv */
// Shared arithmetic unit: bit-serial square root, bit-serial division, registered multiply.
// Depends on chf_pkg for operation codes and the request struct.
module chf_alu
	import chf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  chf_req_t                 req,
	input  logic signed [DATA_W-1:0] opa,
	input  logic signed [DATA_W-1:0] opb,
	output logic                     busy,
	output logic                     done,
	output logic [ROOT_W-1:0]        root,
	output logic signed [DATA_W-1:0] quot,
	output logic signed [PROD_W-1:0] prod
);

	logic [1:0]        op_q;
	logic              busy_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	// square root state
	logic [47:0]       rad_q;
	logic [25:0]       srem_q;
	logic [ROOT_W-1:0] root_q;
	// divider state
	logic [47:0]       dvd_q;
	logic [23:0]       drem_q;
	logic [23:0]       dsr_q;
	logic              neg_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [27:0] s_rem_n;
	logic [27:0] s_trial;
	logic [24:0] d_rem_n;
	logic [24:0] d_dsr;
	logic [31:0] mag;

	// one step of each iteration
	always_comb begin
		s_rem_n = {srem_q, rad_q[47:46]};
		s_trial = {2'b00, root_q, 2'b01};
		d_rem_n = {drem_q, dvd_q[47]};
		d_dsr   = {1'b0, dsr_q};
		mag     = opa[31] ? 32'(-opa) : 32'(opa);
	end

	// sequencing of the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_SQRT;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q <= req.op;
				case (req.op)
					OP_SQRT: begin
						busy_q <= 1'b1;
						cnt_q  <= 6'd24;
					end
					OP_DIV: begin
						busy_q <= 1'b1;
						cnt_q  <= 6'd48;
					end
					default: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			case (req.op)
				OP_SQRT: begin
					rad_q  <= {opa, 16'h0000};
					srem_q <= '0;
					root_q <= '0;
				end
				OP_DIV: begin
					dvd_q  <= {mag, 16'h0000};
					drem_q <= '0;
					dsr_q  <= opb[23:0];
					neg_q  <= opa[31];
				end
				default: begin
					prod_q <= opa * opb;
				end
			endcase
		end else if (busy_q) begin
			if (op_q == OP_SQRT) begin
				rad_q <= {rad_q[45:0], 2'b00};
				if (s_rem_n >= s_trial) begin
					srem_q <= 26'(s_rem_n - s_trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					srem_q <= s_rem_n[25:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end else begin
				if (d_rem_n >= d_dsr) begin
					drem_q <= 24'(d_rem_n - d_dsr);
					dvd_q  <= {dvd_q[46:0], 1'b1};
				end else begin
					drem_q <= d_rem_n[23:0];
					dvd_q  <= {dvd_q[46:0], 1'b0};
				end
			end
		end
	end

	// saturate the signed quotient
	always_comb begin
		if (!neg_q) begin
			if (dvd_q > 48'h0000_7FFF_FFFF) quot = 32'sh7FFF_FFFF;
			else                            quot = signed'(dvd_q[31:0]);
		end else begin
			if (dvd_q > 48'h0000_8000_0000) quot = 32'sh8000_0000;
			else                            quot = signed'(32'(-dvd_q[31:0]));
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;
	assign prod = prod_q;

endmodule

/* design/cholesky_upper_factor_core.sv */
// Top level of the cholesky upper factor core: load store, sequencer and output register.
// Depends on chf_pkg and instantiates chf_alu.
//
// Usage: configure the order with cfg_we/cfg_data while idle (reset order is 8,
// zero acts as 1, values above MAX_ORDER act as MAX_ORDER). Send n*n signed
// Q16.16 elements row-major on the input channel (in_valid/in_stall/element);
// one transaction is taken per cycle while loading. The transaction that
// completes the matrix starts the factorization and in_stall stays high until
// the whole factor has been delivered.
// Each pivot runs a square root of 24 iterations, each off-diagonal division
// 48 iterations of the shared unit, and each trailing update makes three store
// reads through the one read port.
// Results leave on out_valid/out_stall as value/is_last/failed, row-major,
// one transaction at a time through the read, wait and hold states; a stall
// simply holds the output register. On a non-positive pivot the work stops and every
// transaction carries failed. Reset clears the load count, flag and sequencer;
// the store contents are not cleared.
module cholesky_upper_factor_core
	import chf_pkg::*;
#(
	parameter int MAX_ORDER = MAX_ORDER_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [ORD_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] element,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] value,
	output logic                     is_last,
	output logic                     failed
);

	localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam logic [ORD_W-1:0] NMAX = ORD_W'(MAX_ORDER);

	localparam logic [3:0] S_LOAD   = 4'd0;
	localparam logic [3:0] S_PIV_RD = 4'd1;
	localparam logic [3:0] S_PIV_WT = 4'd2;
	localparam logic [3:0] S_SQRT   = 4'd3;
	localparam logic [3:0] S_DIV_RD = 4'd4;
	localparam logic [3:0] S_DIV_WT = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_UA     = 4'd7;
	localparam logic [3:0] S_UB     = 4'd8;
	localparam logic [3:0] S_UC     = 4'd9;
	localparam logic [3:0] S_UW     = 4'd10;
	localparam logic [3:0] S_ORD    = 4'd11;
	localparam logic [3:0] S_OWT    = 4'd12;
	localparam logic [3:0] S_OHOLD  = 4'd13;

	logic [3:0]        state_q;
	logic [ORD_W-1:0]  order_q;
	logic [ORD_W-1:0]  n_eff;
	logic [ORD_W-1:0]  n_q;
	logic [CNT_W-1:0]  load_cnt_q;
	logic [CNT_W:0]    load_next;
	logic [CNT_W:0]    total;
	logic [ORD_W-1:0]  k_q, i_q, j_q;
	logic              fail_q;
	logic [ROOT_W-1:0] root_q;
	logic signed [DATA_W-1:0] opa_q;

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;
	logic [ADDR_W-1:0]        raddr;
	logic [ADDR_W-1:0]        waddr;
	logic signed [DATA_W-1:0] wdata;
	logic                     we;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     is_last_q;
	logic                     failed_q;

	chf_req_t                 req;
	logic signed [DATA_W-1:0] alu_a, alu_b;
	logic                     alu_busy, alu_done;
	logic [ROOT_W-1:0]        alu_root;
	logic signed [DATA_W-1:0] alu_quot;
	logic signed [PROD_W-1:0] alu_prod;
	logic signed [48:0]       diff;
	logic signed [DATA_W-1:0] diff_sat;
	logic                     in_acc, out_acc;

	function automatic logic [ADDR_W-1:0] idx(input logic [ORD_W-1:0] r,
			input logic [ORD_W-1:0] c, input logic [ORD_W-1:0] n);
		logic [2*ORD_W-1:0] t;
		t = r * n + {{ORD_W{1'b0}}, c};
		return t[ADDR_W-1:0];
	endfunction

	chf_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (alu_a),
		.opb    (alu_b),
		.busy   (alu_busy),
		.done   (alu_done),
		.root   (alu_root),
		.quot   (alu_quot),
		.prod   (alu_prod)
	);

	// effective order and load bookkeeping
	always_comb begin
		if (order_q == '0)       n_eff = 4'd1;
		else if (order_q > NMAX) n_eff = NMAX;
		else                     n_eff = order_q;
		total     = (CNT_W+1)'({{ORD_W{1'b0}}, n_eff} * {{ORD_W{1'b0}}, n_eff});
		load_next = {1'b0, load_cnt_q} + 1'b1;
		in_acc    = in_valid && !in_stall;
		out_acc   = out_valid_q && !out_stall;
	end

	// trailing update: subtract floored product and saturate
	always_comb begin
		diff = 49'(rdata_q) - 49'(alu_prod >>> 16);
		if (diff > 49'sh0_7FFF_FFFF)       diff_sat = 32'sh7FFF_FFFF;
		else if (diff < -49'sh0_8000_0000) diff_sat = 32'sh8000_0000;
		else                               diff_sat = diff[31:0];
	end

	// store addressing, write selection and arithmetic unit requests
	always_comb begin
		raddr     = idx(k_q, k_q, n_q);
		waddr     = load_cnt_q[ADDR_W-1:0];
		wdata     = element;
		we        = 1'b0;
		req.start = 1'b0;
		req.op    = OP_SQRT;
		alu_a     = rdata_q;
		alu_b     = signed'({{(DATA_W-ROOT_W){1'b0}}, root_q});
		case (state_q)
			S_LOAD:   we = in_acc;
			S_PIV_WT: req.start = !(rdata_q <= 0);
			S_SQRT: begin
				we    = alu_done;
				waddr = idx(k_q, k_q, n_q);
				wdata = signed'({{(DATA_W-ROOT_W){1'b0}}, alu_root});
			end
			S_DIV_RD: raddr = idx(k_q, j_q, n_q);
			S_DIV_WT: begin
				req.start = 1'b1;
				req.op    = OP_DIV;
			end
			S_DIV: begin
				we    = alu_done;
				waddr = idx(k_q, j_q, n_q);
				wdata = alu_quot;
			end
			S_UA: raddr = idx(k_q, i_q, n_q);
			S_UB: raddr = idx(k_q, j_q, n_q);
			S_UC: begin
				raddr     = idx(i_q, j_q, n_q);
				req.start = 1'b1;
				req.op    = OP_MUL;
				alu_a     = opa_q;
				alu_b     = rdata_q;
			end
			S_UW: begin
				we    = 1'b1;
				waddr = idx(i_q, j_q, n_q);
				wdata = diff_sat;
			end
			S_ORD: raddr = idx(i_q, j_q, n_q);
			default: ;
		endcase
	end

	// matrix store, registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// operand and output payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_UB) opa_q <= rdata_q;
		if (state_q == S_SQRT && alu_done) root_q <= alu_root;
		if (state_q == S_OWT) begin
			value_q   <= (j_q < i_q) ? '0 : rdata_q;
			is_last_q <= (i_q == n_q - 4'd1) && (j_q == n_q - 4'd1);
			failed_q  <= fail_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			order_q     <= ORDER_RESET;
			n_q         <= ORDER_RESET;
			load_cnt_q  <= '0;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			fail_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) order_q <= cfg_data;
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (load_next >= total) begin
							load_cnt_q <= '0;
							n_q        <= n_eff;
							k_q        <= '0;
							fail_q     <= 1'b0;
							state_q    <= S_PIV_RD;
						end else begin
							load_cnt_q <= load_next[CNT_W-1:0];
						end
					end
				end
				S_PIV_RD: state_q <= S_PIV_WT;
				S_PIV_WT: begin
					if (rdata_q <= 0) begin
						fail_q  <= 1'b1;
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_ORD;
					end else begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (alu_done) begin
						if (4'(k_q + 4'd1) < n_q) begin
							j_q     <= k_q + 4'd1;
							state_q <= S_DIV_RD;
						end else begin
							i_q     <= '0;
							j_q     <= '0;
							state_q <= S_ORD;
						end
					end
				end
				S_DIV_RD: state_q <= S_DIV_WT;
				S_DIV_WT: state_q <= S_DIV;
				S_DIV: begin
					if (alu_done) begin
						if (4'(j_q + 4'd1) < n_q) begin
							j_q     <= j_q + 4'd1;
							state_q <= S_DIV_RD;
						end else begin
							i_q     <= k_q + 4'd1;
							j_q     <= k_q + 4'd1;
							state_q <= S_UA;
						end
					end
				end
				S_UA: state_q <= S_UB;
				S_UB: state_q <= S_UC;
				S_UC: state_q <= S_UW;
				S_UW: begin
					if (4'(j_q + 4'd1) < n_q) begin
						j_q     <= j_q + 4'd1;
						state_q <= S_UA;
					end else if (4'(i_q + 4'd1) < n_q) begin
						i_q     <= i_q + 4'd1;
						j_q     <= i_q + 4'd1;
						state_q <= S_UA;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= S_PIV_RD;
					end
				end
				S_ORD: state_q <= S_OWT;
				S_OWT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OHOLD;
				end
				S_OHOLD: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (is_last_q) begin
							state_q <= S_LOAD;
						end else if (4'(j_q + 4'd1) < n_q) begin
							j_q     <= j_q + 4'd1;
							state_q <= S_ORD;
						end else begin
							i_q     <= i_q + 4'd1;
							j_q     <= '0;
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign in_stall  = (state_q != S_LOAD);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign is_last   = is_last_q;
	assign failed    = failed_q;

	// no result offered while loading
	a_no_out_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> !out_valid_q)
		else $error("result offered during load");

	// load count stays inside the store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(load_cnt_q < CNT_W'(DEPTH)))
		else $error("load count beyond store depth");

	// final transaction returns the block to loading
	a_last_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && is_last_q) |=> (state_q == S_LOAD))
		else $error("no return to load after last transaction");

	// arithmetic unit never restarted while iterating
	a_alu_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !alu_busy)
		else $error("arithmetic unit started while busy");

endmodule
